[rtl/core/wptc_pkg.sv]
// ----------------------------------------------------------------------------
// wptc_pkg
// Shared types and constants for the windowed peak threshold cluster block.
// ----------------------------------------------------------------------------
package wptc_pkg;

   localparam int DEF_SAMPLE_BITS = 16;
   localparam int DEF_INDEX_BITS  = 32;

   localparam int THR_BITS   = 32;
   localparam int WSIZE_BITS = 17;
   localparam logic [WSIZE_BITS-1:0] WSIZE_RESET = 17'd1024;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // register select, taken from the word address bit
   typedef enum logic {
      REG_THRESHOLD   = 1'b0,
      REG_WINDOW_SIZE = 1'b1
   } reg_sel_type;

   // number of result beats raised by one sample
   typedef enum logic [1:0] {
      PUSH_NONE = 2'd0,
      PUSH_ONE  = 2'd1,
      PUSH_TWO  = 2'd2
   } push_type;

   typedef struct packed {
      logic [THR_BITS-1:0]   threshold_squared;
      logic [WSIZE_BITS-1:0] window_size;
   } cfg_type;

endpackage

[rtl/core/wptc_norm.sv]
// ----------------------------------------------------------------------------
// wptc_norm
// Input register stage: captures a sample beat and its squared magnitude.
// ----------------------------------------------------------------------------
module wptc_norm #(
   parameter int SAMPLE_BITS = wptc_pkg::DEF_SAMPLE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [SAMPLE_BITS-1:0] in_re,
   input  logic signed [SAMPLE_BITS-1:0] in_im,
   input  logic                          in_last,
   input  logic                          take,
   output logic                          out_valid,
   output logic signed [SAMPLE_BITS-1:0] out_re,
   output logic signed [SAMPLE_BITS-1:0] out_im,
   output logic                          out_last,
   output logic [2*SAMPLE_BITS-1:0]      out_norm
);
   import wptc_pkg::*;

   localparam int NORM_BITS = 2 * SAMPLE_BITS;

   logic                          accept;
   logic                          valid_ff, valid_in;
   logic signed [NORM_BITS-1:0]   re_sq, im_sq;
   logic [NORM_BITS-1:0]          norm_in, norm_ff;
   logic signed [SAMPLE_BITS-1:0] re_ff, im_ff;
   logic                          last_ff;

   assign in_ready = !valid_ff || take;
   assign accept   = in_valid && in_ready;

   // exact norm; the sum of two squares always fits in 2*SAMPLE_BITS unsigned
   assign re_sq   = in_re * in_re;
   assign im_sq   = in_im * in_im;
   assign norm_in = $unsigned(re_sq) + $unsigned(im_sq);

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         re_ff   <= in_re;
         im_ff   <= in_im;
         last_ff <= in_last;
         norm_ff <= norm_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_re    = re_ff;
   assign out_im    = im_ff;
   assign out_last  = last_ff;
   assign out_norm  = norm_ff;

endmodule

[rtl/core/wptc_cluster.sv]
// ----------------------------------------------------------------------------
// wptc_cluster
// Window maximum tracking, threshold test and neighbour clustering decision.
// ----------------------------------------------------------------------------
module wptc_cluster #(
   parameter int SAMPLE_BITS = wptc_pkg::DEF_SAMPLE_BITS,
   parameter int INDEX_BITS  = wptc_pkg::DEF_INDEX_BITS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    fire,
   input  wptc_pkg::cfg_type                       cfg,
   input  logic signed [SAMPLE_BITS-1:0]           s_re,
   input  logic signed [SAMPLE_BITS-1:0]           s_im,
   input  logic                                    s_last,
   input  logic [2*SAMPLE_BITS-1:0]                s_norm,
   output wptc_pkg::push_type                      push,
   // result words, from lowest bit up: re, im, location
   output logic [2*SAMPLE_BITS+INDEX_BITS-1:0]     res0,
   output logic [2*SAMPLE_BITS+INDEX_BITS-1:0]     res1
);
   import wptc_pkg::*;

   localparam int NB = 2 * SAMPLE_BITS;
   localparam int CB = (NB > THR_BITS) ? NB : THR_BITS;

   logic [INDEX_BITS-1:0]         idx_ff, idx_in;
   logic [WSIZE_BITS-1:0]         fill_ff, fill_in;
   logic [NB-1:0]                 cur_norm_ff, cur_norm_in;
   logic signed [SAMPLE_BITS-1:0] cur_re_ff, cur_re_in, cur_im_ff, cur_im_in;
   logic [INDEX_BITS-1:0]         cur_loc_ff, cur_loc_in;
   logic [NB-1:0]                 pend_norm_ff, pend_norm_in;
   logic signed [SAMPLE_BITS-1:0] pend_re_ff, pend_re_in, pend_im_ff, pend_im_in;
   logic [INDEX_BITS-1:0]         pend_loc_ff, pend_loc_in;
   logic [NB-1:0]                 earlier_ff, earlier_in;
   logic [1:0]                    wc_ff, wc_in;

   logic [WSIZE_BITS-1:0]         wsize, fill_nx;
   logic [CB-1:0]                 thr;
   logic [NB-1:0]                 base_norm, cur_norm, earlier_post;
   logic signed [SAMPLE_BITS-1:0] base_re, base_im, cur_re, cur_im;
   logic [INDEX_BITS-1:0]         base_loc, cur_loc;
   logic [1:0]                    wc_post;
   logic                          close, pend_gt_thr, cur_gt_thr, hit_a, hit_b;
   logic                          a_fires, b_fires;
   logic [NB+INDEX_BITS-1:0]      pend_word, cur_word;

   always_comb begin
      wsize = (cfg.window_size == '0) ? WSIZE_BITS'(1) : cfg.window_size;
      thr   = CB'(cfg.threshold_squared);

      // a fresh window starts from zero at its first index
      if (fill_ff == '0) begin
         base_norm = '0;
         base_re   = '0;
         base_im   = '0;
         base_loc  = idx_ff;
      end else begin
         base_norm = cur_norm_ff;
         base_re   = cur_re_ff;
         base_im   = cur_im_ff;
         base_loc  = cur_loc_ff;
      end

      if (s_norm > base_norm) begin
         cur_norm = s_norm;
         cur_re   = s_re;
         cur_im   = s_im;
         cur_loc  = idx_ff;
      end else begin
         cur_norm = base_norm;
         cur_re   = base_re;
         cur_im   = base_im;
         cur_loc  = base_loc;
      end

      fill_nx = fill_ff + 1'b1;
      close   = (fill_nx >= wsize) || s_last;

      pend_gt_thr = CB'(pend_norm_ff) > thr;
      cur_gt_thr  = CB'(cur_norm) > thr;

      // waiting window, judged once its successor closes
      case (wc_ff)
         2'd1:    hit_a = pend_gt_thr && (pend_norm_ff > cur_norm);
         2'd2:    hit_a = pend_gt_thr && (pend_norm_ff > earlier_ff) &&
                          (pend_norm_ff >= cur_norm);
         default: hit_a = 1'b0;
      endcase

      earlier_post = (wc_ff != 2'd0) ? pend_norm_ff : earlier_ff;
      wc_post      = (wc_ff == 2'd2) ? 2'd2 : wc_ff + 2'd1;

      // window closed by end of array: lone or last
      if (wc_post == 2'd1) begin
         hit_b = cur_gt_thr;
      end else begin
         hit_b = cur_gt_thr && (cur_norm > earlier_post);
      end

      a_fires = fire && close && hit_a;
      b_fires = fire && s_last && hit_b;

      pend_word = {pend_loc_ff, pend_im_ff, pend_re_ff};
      cur_word  = {cur_loc, cur_im, cur_re};

      push = PUSH_NONE;
      res0 = pend_word;
      res1 = cur_word;
      if (a_fires && b_fires) begin
         push = PUSH_TWO;
      end else if (a_fires) begin
         push = PUSH_ONE;
      end else if (b_fires) begin
         push = PUSH_ONE;
         res0 = cur_word;
      end
   end

   always_comb begin
      idx_in       = idx_ff;
      fill_in      = fill_ff;
      cur_norm_in  = cur_norm_ff;
      cur_re_in    = cur_re_ff;
      cur_im_in    = cur_im_ff;
      cur_loc_in   = cur_loc_ff;
      pend_norm_in = pend_norm_ff;
      pend_re_in   = pend_re_ff;
      pend_im_in   = pend_im_ff;
      pend_loc_in  = pend_loc_ff;
      earlier_in   = earlier_ff;
      wc_in        = wc_ff;
      if (fire) begin
         if (s_last) begin
            idx_in       = '0;
            fill_in      = '0;
            cur_norm_in  = '0;
            cur_re_in    = '0;
            cur_im_in    = '0;
            cur_loc_in   = '0;
            pend_norm_in = '0;
            pend_re_in   = '0;
            pend_im_in   = '0;
            pend_loc_in  = '0;
            earlier_in   = '0;
            wc_in        = '0;
         end else begin
            idx_in      = idx_ff + 1'b1;
            cur_norm_in = cur_norm;
            cur_re_in   = cur_re;
            cur_im_in   = cur_im;
            cur_loc_in  = cur_loc;
            if (close) begin
               fill_in      = '0;
               earlier_in   = earlier_post;
               pend_norm_in = cur_norm;
               pend_re_in   = cur_re;
               pend_im_in   = cur_im;
               pend_loc_in  = cur_loc;
               wc_in        = wc_post;
            end else begin
               fill_in = fill_nx;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         fill_ff      <= '0;
         cur_norm_ff  <= '0;
         cur_re_ff    <= '0;
         cur_im_ff    <= '0;
         cur_loc_ff   <= '0;
         pend_norm_ff <= '0;
         pend_re_ff   <= '0;
         pend_im_ff   <= '0;
         pend_loc_ff  <= '0;
         earlier_ff   <= '0;
         wc_ff        <= '0;
      end else begin
         idx_ff       <= idx_in;
         fill_ff      <= fill_in;
         cur_norm_ff  <= cur_norm_in;
         cur_re_ff    <= cur_re_in;
         cur_im_ff    <= cur_im_in;
         cur_loc_ff   <= cur_loc_in;
         pend_norm_ff <= pend_norm_in;
         pend_re_ff   <= pend_re_in;
         pend_im_ff   <= pend_im_in;
         pend_loc_ff  <= pend_loc_in;
         earlier_ff   <= earlier_in;
         wc_ff        <= wc_in;
      end
   end

endmodule

[rtl/core/wptc_result_queue.sv]
// ----------------------------------------------------------------------------
// wptc_result_queue
// Four-deep shifting output queue; takes up to two result beats per cycle.
// ----------------------------------------------------------------------------
module wptc_result_queue #(
   parameter int ENTRY_BITS = 2 * wptc_pkg::DEF_SAMPLE_BITS + wptc_pkg::DEF_INDEX_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  wptc_pkg::push_type    push,
   input  logic [ENTRY_BITS-1:0] push0,
   input  logic [ENTRY_BITS-1:0] push1,
   output logic                  room,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [ENTRY_BITS-1:0] out_data,
   output logic                  out_last
);
   import wptc_pkg::*;

   localparam int DEPTH    = 4;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   // entry MSB is the last-beat flag
   logic [ENTRY_BITS:0]   q_ff [DEPTH];
   logic [ENTRY_BITS:0]   q_in [DEPTH];
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in, base, base_nx, n_push;
   logic                  pop;

   assign pop     = (cnt_ff != '0) && out_ready;
   assign base    = cnt_ff - CNT_BITS'(pop);
   assign base_nx = base + 1'b1;

   always_comb begin
      case (push)
         PUSH_ONE: n_push = CNT_BITS'(1);
         PUSH_TWO: n_push = CNT_BITS'(2);
         default:  n_push = '0;
      endcase
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         q_in[i] = q_ff[i];
      end
      if (pop) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            q_in[i] = q_ff[i+1];
         end
      end
      for (int i = 0; i < DEPTH; i++) begin
         if ((n_push != '0) && (CNT_BITS'(i) == base)) begin
            q_in[i] = {(push == PUSH_ONE), push0};
         end
         if ((push == PUSH_TWO) && (CNT_BITS'(i) == base_nx)) begin
            q_in[i] = {1'b1, push1};
         end
      end
      cnt_in = base + n_push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

   // two free slots guarantee space for the worst-case sample
   assign room      = cnt_ff <= CNT_BITS'(DEPTH - 2);
   assign out_valid = cnt_ff != '0;
   assign out_data  = q_ff[0][ENTRY_BITS-1:0];
   assign out_last  = q_ff[0][ENTRY_BITS];

endmodule

[rtl/core/windowed_peak_threshold_cluster_top.sv]
// The norm stage registers each sample beat and the output queue registers the
// result beats. Throughput: one sample per cycle while the output queue has room,
// set by the norm and decision stages; an end-of-array sample may raise two
// result beats, drained by a four-deep queue. Synchronous active-high reset clears
// valid, count and cluster state, restores threshold_squared to 0, window_size to 1024.
// ----------------------------------------------------------------------------
// windowed_peak_threshold_cluster_top
// Windowed maximum with threshold and neighbour clustering over a sample stream.
// ----------------------------------------------------------------------------
module windowed_peak_threshold_cluster_top #(
   parameter int SAMPLE_BITS = wptc_pkg::DEF_SAMPLE_BITS,
   parameter int INDEX_BITS  = wptc_pkg::DEF_INDEX_BITS
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_tvalid,
   output logic                                          req_tready,
   // sample_re, sample_im, zero pad
   input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]            req_tdata,
   // end_of_array
   input  logic                                          req_tlast,
   output logic                                          rsp_tvalid,
   input  logic                                          rsp_tready,
   // peak_re, peak_im, peak_location, zero pad
   output logic [((2*SAMPLE_BITS+INDEX_BITS+7)/8)*8-1:0] rsp_tdata,
   // last_of_run
   output logic                                          rsp_tlast,
   input  logic                                          csr_psel,
   input  logic                                          csr_penable,
   input  logic                                          csr_pwrite,
   input  logic [wptc_pkg::CSR_ADDR_BITS-1:0]            csr_paddr,
   input  logic [wptc_pkg::CSR_DATA_BITS-1:0]            csr_pwdata,
   output logic [wptc_pkg::CSR_DATA_BITS-1:0]            csr_prdata,
   output logic                                          csr_pready
);
   import wptc_pkg::*;

   localparam int OUT_BITS = ((2 * SAMPLE_BITS + INDEX_BITS + 7) / 8) * 8;
   localparam int RES_BITS = 2 * SAMPLE_BITS + INDEX_BITS;

   cfg_type                       cfg_ff, cfg_in;
   reg_sel_type                   reg_sel;
   logic                          csr_write;

   logic                          s1_valid, s1_last, fire, room;
   logic signed [SAMPLE_BITS-1:0] s1_re, s1_im;
   logic [2*SAMPLE_BITS-1:0]      s1_norm;
   push_type                      push;
   logic [RES_BITS-1:0]           res0, res1, head;

   // ---- configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = reg_sel_type'(csr_paddr[2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (reg_sel)
            REG_THRESHOLD:   cfg_in.threshold_squared = csr_pwdata[THR_BITS-1:0];
            REG_WINDOW_SIZE: cfg_in.window_size       = csr_pwdata[WSIZE_BITS-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_THRESHOLD:   csr_prdata = CSR_DATA_BITS'(cfg_ff.threshold_squared);
         REG_WINDOW_SIZE: csr_prdata = CSR_DATA_BITS'(cfg_ff.window_size);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold_squared <= '0;
         cfg_ff.window_size       <= WSIZE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---- datapath
   assign fire = s1_valid && room;

   wptc_norm #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_re     (req_tdata[SAMPLE_BITS-1:0]),
      .in_im     (req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
      .in_last   (req_tlast),
      .take      (fire),
      .out_valid (s1_valid),
      .out_re    (s1_re),
      .out_im    (s1_im),
      .out_last  (s1_last),
      .out_norm  (s1_norm)
   );

   wptc_cluster #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .INDEX_BITS  (INDEX_BITS)
   ) u_cluster (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .cfg    (cfg_ff),
      .s_re   (s1_re),
      .s_im   (s1_im),
      .s_last (s1_last),
      .s_norm (s1_norm),
      .push   (push),
      .res0   (res0),
      .res1   (res1)
   );

   wptc_result_queue #(
      .ENTRY_BITS (RES_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push0     (res0),
      .push1     (res1),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (head),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = OUT_BITS'(head);

endmodule
